### src/wsc_pkg.sv
// shared types, constants and the arctangent table of the waypoint step command
`default_nettype none

package wsc_pkg;

    // command codes on the result word
    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_ELEVATE = 2'd1,
        CMD_ROTATE  = 2'd2,
        CMD_ADVANCE = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] REG_ELEVATE_LIMIT    = 2'd0;
    localparam logic [1:0] REG_ROTATE_LIMIT     = 2'd1;
    localparam logic [1:0] REG_ADVANCE_DISTANCE = 2'd2;

    // reset values of the configuration registers
    localparam logic [22:0] ELEVATE_LIMIT_RST    = 23'd25600;
    localparam logic [15:0] ROTATE_LIMIT_RST     = 16'd23040;
    localparam logic [22:0] ADVANCE_DISTANCE_RST = 23'd25600;

    // datapath widths
    localparam int PW = 24;  // position field
    localparam int DW = 25;  // position difference
    localparam int HW = 18;  // heading field
    localparam int XW = 37;  // cordic x/y, difference scaled by 256 plus gain growth
    localparam int ZW = 27;  // cordic angle in 1/65536 degree
    localparam int AW = ZW - 8;  // angle in 1/256 degree
    localparam int EW = 20;  // angle difference before wrapping
    localparam int MW = 17;  // rotate magnitude, at most a half turn

    // turn constants in 1/256 degree and 1/65536 degree
    localparam logic signed [EW-1:0] FULL_TURN      = 20'sd92160;
    localparam logic signed [EW-1:0] TWO_TURNS      = 20'sd184320;
    localparam logic signed [EW-1:0] HALF_TURN      = 20'sd46080;
    localparam logic signed [ZW-1:0] HALF_TURN_FINE = 27'sd11796480;
    localparam logic signed [ZW-1:0] ROUND_HALF     = 27'sd128;

    // values that travel beside the cordic datapath
    typedef struct packed {
        logic                   elev;
        logic                   move;
        logic signed [PW-1:0]   elev_amt;
        logic signed [HW-1:0]   heading;
    } side_t;

    // atan(2^-i) in degrees times 65536, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] val;
        begin
            case (idx)
                5'd0:    val = 27'sd2949120;
                5'd1:    val = 27'sd1740967;
                5'd2:    val = 27'sd919879;
                5'd3:    val = 27'sd466945;
                5'd4:    val = 27'sd234379;
                5'd5:    val = 27'sd117304;
                5'd6:    val = 27'sd58666;
                5'd7:    val = 27'sd29335;
                5'd8:    val = 27'sd14668;
                5'd9:    val = 27'sd7334;
                5'd10:   val = 27'sd3667;
                5'd11:   val = 27'sd1833;
                5'd12:   val = 27'sd917;
                5'd13:   val = 27'sd458;
                5'd14:   val = 27'sd229;
                5'd15:   val = 27'sd115;
                5'd16:   val = 27'sd57;
                5'd17:   val = 27'sd29;
                5'd18:   val = 27'sd14;
                5'd19:   val = 27'sd7;
                5'd20:   val = 27'sd4;
                5'd21:   val = 27'sd2;
                5'd22:   val = 27'sd1;
                default: val = 27'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

### src/waypoint_step_command.sv
// waypoint step command: pipelined elevate / rotate / advance decision with cordic atan2
//
// channel   | direction | handshake         | contents
// ----------+-----------+-------------------+-------------------------------------------
// query     | in        | start, busy       | pos_x pos_y pos_h heading target_x/y/h
// command   | out       | done (strobe)     | command amount turn_right
// config    | in        | cfg_we            | cfg_index cfg_data
//
// one word enters per cycle; each word passes through the unrolled cordic
// pipeline (one rotation stage per iteration) plus two front stages and three
// back stages for rounding and heading subtraction, full-turn remainder, and wrap, limit and command select.
// busy is always low: the pipeline never stops, so the receiver takes every
// result in the single cycle that done marks it.
// reset clears all valid bits and loads the configuration reset values.
`default_nettype none

module waypoint_step_command #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // query word
    input  wire logic                start,
    output logic                     busy,
    input  wire logic signed [23:0]  pos_x,
    input  wire logic signed [23:0]  pos_y,
    input  wire logic signed [23:0]  pos_h,
    input  wire logic signed [17:0]  heading,
    input  wire logic signed [23:0]  target_x,
    input  wire logic signed [23:0]  target_y,
    input  wire logic signed [23:0]  target_h,
    // command word
    output logic                     done,
    output logic [1:0]               command,
    output logic signed [23:0]       amount,
    output logic                     turn_right,
    // configuration
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [22:0]         cfg_data
);
    import wsc_pkg::*;

    // configuration registers
    logic [22:0] elevate_limit_reg;
    logic [15:0] rotate_limit_reg;
    logic [22:0] advance_distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elevate_limit_reg    <= ELEVATE_LIMIT_RST;
            rotate_limit_reg     <= ROTATE_LIMIT_RST;
            advance_distance_reg <= ADVANCE_DISTANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ELEVATE_LIMIT:    elevate_limit_reg    <= cfg_data;
                REG_ROTATE_LIMIT:     rotate_limit_reg     <= cfg_data[15:0];
                REG_ADVANCE_DISTANCE: advance_distance_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 0: differences
    logic                  s0_valid_reg;
    logic signed [DW-1:0]  dx_reg, dy_reg, dh_reg;
    logic signed [HW-1:0]  s0_heading_reg;
    logic signed [DW-1:0]  dx_next, dy_next, dh_next;

    always_comb
    begin
        dx_next = DW'(target_x) - DW'(pos_x);
        dy_next = DW'(target_y) - DW'(pos_y);
        dh_next = DW'(target_h) - DW'(pos_h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        dh_reg         <= dh_next;
        s0_heading_reg <= heading;
    end

    // cordic pipeline arrays; index 0 is the pre-rotated vector
    logic                  valid_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0]  x_reg     [0:CORDIC_STEPS];
    logic signed [XW-1:0]  y_reg     [0:CORDIC_STEPS];
    logic signed [ZW-1:0]  z_reg     [0:CORDIC_STEPS];
    side_t                 side_reg  [0:CORDIC_STEPS];
    logic signed [XW-1:0]  x_next    [0:CORDIC_STEPS];
    logic signed [XW-1:0]  y_next    [0:CORDIC_STEPS];
    logic signed [ZW-1:0]  z_next    [0:CORDIC_STEPS];
    side_t                 side_next [0:CORDIC_STEPS];

    // stage 1: left half plane fold and elevate clamp
    logic signed [XW-1:0] x_scaled, y_scaled;
    logic signed [DW-1:0] elev_lim;

    always_comb
    begin
        x_scaled = {{(XW-DW-8){dx_reg[DW-1]}}, dx_reg, 8'b0};
        y_scaled = {{(XW-DW-8){dy_reg[DW-1]}}, dy_reg, 8'b0};
        elev_lim = $signed({2'b00, elevate_limit_reg});
        if (dx_reg < 0)
        begin
            x_next[0] = -x_scaled;
            y_next[0] = -y_scaled;
            z_next[0] = (dy_reg >= 0) ? HALF_TURN_FINE : -HALF_TURN_FINE;
        end
        else
        begin
            x_next[0] = x_scaled;
            y_next[0] = y_scaled;
            z_next[0] = '0;
        end
        side_next[0].elev    = (dh_reg != 0);
        side_next[0].move    = (dx_reg != 0) || (dy_reg != 0);
        side_next[0].heading = s0_heading_reg;
        if (dh_reg > elev_lim)
            side_next[0].elev_amt = elev_lim[PW-1:0];
        else if (dh_reg < -elev_lim)
            side_next[0].elev_amt = PW'(-elev_lim);
        else
            side_next[0].elev_amt = dh_reg[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_next[0];
        y_reg[0]    <= y_next[0];
        z_reg[0]    <= z_next[0];
        side_reg[0] <= side_next[0];
    end

    // cordic rotation stages, one iteration each
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        always_comb
        begin
            if (y_reg[i] >= 0)
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + atan_entry(5'(i));
            end
            else
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - atan_entry(5'(i));
            end
            side_next[i+1] = side_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next[i+1];
            y_reg[i+1]    <= y_next[i+1];
            z_reg[i+1]    <= z_next[i+1];
            side_reg[i+1] <= side_next[i+1];
        end
    end

    // back stage 1: round angle to 1/256 degree and subtract heading
    logic                  f1_valid_reg;
    logic signed [EW-1:0]  f1_delta_reg;
    side_t                 f1_side_reg;
    logic signed [ZW-1:0]  z_round;
    logic signed [AW-1:0]  angle;
    logic signed [EW-1:0]  f1_delta_next;

    always_comb
    begin
        z_round       = z_reg[CORDIC_STEPS] + ROUND_HALF;
        angle         = z_round[ZW-1:8];
        f1_delta_next = EW'(angle) - EW'(side_reg[CORDIC_STEPS].heading);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= valid_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        f1_delta_reg <= f1_delta_next;
        f1_side_reg  <= side_reg[CORDIC_STEPS];
    end

    // back stage 2: truncating remainder by a full turn
    logic                  f2_valid_reg;
    logic signed [EW-1:0]  f2_rem_reg;
    side_t                 f2_side_reg;
    logic signed [EW-1:0]  f2_rem_next;

    always_comb
    begin
        if (f1_delta_reg >= TWO_TURNS)
            f2_rem_next = f1_delta_reg - TWO_TURNS;
        else if (f1_delta_reg >= FULL_TURN)
            f2_rem_next = f1_delta_reg - FULL_TURN;
        else if (f1_delta_reg <= -TWO_TURNS)
            f2_rem_next = f1_delta_reg + TWO_TURNS;
        else if (f1_delta_reg <= -FULL_TURN)
            f2_rem_next = f1_delta_reg + FULL_TURN;
        else
            f2_rem_next = f1_delta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_valid_reg <= 1'b0;
        else
            f2_valid_reg <= f1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        f2_rem_reg  <= f2_rem_next;
        f2_side_reg <= f1_side_reg;
    end

    // back stage 3: shortest angle, limits and command select
    logic                  done_reg;
    cmd_t                  command_reg;
    logic signed [PW-1:0]  amount_reg;
    logic                  turn_right_reg;
    cmd_t                  command_next;
    logic signed [PW-1:0]  amount_next;
    logic                  turn_right_next;
    logic signed [EW-1:0]  wrapped;
    logic [MW-1:0]         mag;
    logic [MW-1:0]         rot_amt;

    always_comb
    begin
        if (f2_rem_reg > HALF_TURN)
            wrapped = f2_rem_reg - FULL_TURN;
        else if (f2_rem_reg < -HALF_TURN)
            wrapped = f2_rem_reg + FULL_TURN;
        else
            wrapped = f2_rem_reg;
        mag     = (wrapped < 0) ? MW'(-wrapped) : MW'(wrapped);
        rot_amt = (mag < {1'b0, rotate_limit_reg}) ? mag : {1'b0, rotate_limit_reg};

        command_next    = CMD_NONE;
        amount_next     = '0;
        turn_right_next = 1'b0;
        if (f2_side_reg.elev)
        begin
            command_next = CMD_ELEVATE;
            amount_next  = f2_side_reg.elev_amt;
        end
        else if (f2_side_reg.move)
        begin
            if (wrapped != 0)
            begin
                command_next    = CMD_ROTATE;
                amount_next     = PW'(rot_amt);
                turn_right_next = (wrapped > 0);
            end
            else
            begin
                command_next = CMD_ADVANCE;
                amount_next  = {1'b0, advance_distance_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= f2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        command_reg    <= command_next;
        amount_reg     <= amount_next;
        turn_right_reg <= turn_right_next;
    end

    // result word
    assign done       = done_reg;
    assign command    = command_reg;
    assign amount     = amount_reg;
    assign turn_right = turn_right_reg;

endmodule

`default_nettype wire
